### src/upi_pkg.sv
// ----------------------------------------------------------------------------
// upi_pkg
// Shared types, microcode and constants of the unicycle pose integrator.
// ----------------------------------------------------------------------------
package upi_pkg;

    // Command as it enters the block
    typedef struct packed {
        logic signed [15:0] speed;
        logic signed [15:0] turn_rate;
        logic signed [15:0] progress_rate;
        logic        [15:0] step_time;
    } t_cmd;

    // Pose as it leaves the block
    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic        [15:0] out_heading;
        logic signed [31:0] out_progress;
    } t_pose;

    // Sequencer steps
    typedef enum logic [3:0] {
        ST_WAIT,
        ST_ROT,
        ST_MUL_VDT,
        ST_MUL_WDT,
        ST_MUL_VSDT,
        ST_MUL_VDT_C,
        ST_MUL_VDT_S,
        ST_MUL_WDT_K,
        ST_UPD_HEAD,
        ST_EMIT
    } t_step;

    // Jump conditions: hold the step until the condition is met
    typedef enum logic [1:0] {
        JC_ALWAYS,
        JC_IN_VALID,
        JC_CORDIC_DONE,
        JC_OUT_FREE
    } t_jcond;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_ITER,
        OP_SET_VDT,
        OP_SET_WDT,
        OP_UPD_PROG,
        OP_UPD_X,
        OP_UPD_Y,
        OP_UPD_HEAD,
        OP_EMIT
    } t_dp_op;

    // Multiplier operand selects
    typedef enum logic [2:0] {
        MA_SPEED,
        MA_TURN,
        MA_PROG,
        MA_VDT,
        MA_WDT
    } t_mul_a;

    typedef enum logic [1:0] {
        MB_DT,
        MB_COS,
        MB_SIN,
        MB_TURN_K
    } t_mul_b;

    // One microcode word
    typedef struct packed {
        t_jcond jcond;
        t_step  target;
        t_dp_op op;
        t_mul_a mul_a;
        t_mul_b mul_b;
    } t_uword;

    // Sequencer to datapath
    typedef struct packed {
        logic   take;
        t_dp_op op;
        t_mul_a mul_a;
        t_mul_b mul_b;
    } t_dp_ctrl;

    // Sequencer to CORDIC
    typedef struct packed {
        logic load;
        logic iter;
    } t_cordic_ctrl;

    // Status back to the sequencer
    typedef struct packed {
        logic in_valid;
        logic cordic_done;
        logic out_free;
    } t_seq_status;

    // Arithmetic constants
    localparam logic signed [31:0] INV_GAIN_Q30   = 32'sd652032874;
    localparam logic signed [32:0] TURN_RECIP_Q32 = 33'sd683565276;
    localparam int                 ATAN_DEPTH     = 24;
    localparam int                 ATAN_IDX_W     = 5;

    // atan(2^-i) in 2^-32 turn
    localparam logic [31:0] ATAN_TURN32 [ATAN_DEPTH] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // Microcode ROM
    function automatic t_uword ucode(input t_step step);
        t_uword w;
        w = '{jcond: JC_ALWAYS, target: ST_WAIT, op: OP_NONE,
              mul_a: MA_SPEED, mul_b: MB_DT};
        unique case (step)
            ST_WAIT: begin
                w.jcond = JC_IN_VALID;    w.target = ST_ROT;       w.op = OP_LOAD;
            end
            ST_ROT: begin
                w.jcond = JC_CORDIC_DONE; w.target = ST_MUL_VDT;   w.op = OP_ITER;
            end
            ST_MUL_VDT: begin
                w.target = ST_MUL_WDT;    w.mul_a = MA_SPEED;      w.mul_b = MB_DT;
            end
            ST_MUL_WDT: begin
                w.target = ST_MUL_VSDT;   w.op = OP_SET_VDT;
                w.mul_a  = MA_TURN;       w.mul_b = MB_DT;
            end
            ST_MUL_VSDT: begin
                w.target = ST_MUL_VDT_C;  w.op = OP_SET_WDT;
                w.mul_a  = MA_PROG;       w.mul_b = MB_DT;
            end
            ST_MUL_VDT_C: begin
                w.target = ST_MUL_VDT_S;  w.op = OP_UPD_PROG;
                w.mul_a  = MA_VDT;        w.mul_b = MB_COS;
            end
            ST_MUL_VDT_S: begin
                w.target = ST_MUL_WDT_K;  w.op = OP_UPD_X;
                w.mul_a  = MA_VDT;        w.mul_b = MB_SIN;
            end
            ST_MUL_WDT_K: begin
                w.target = ST_UPD_HEAD;   w.op = OP_UPD_Y;
                w.mul_a  = MA_WDT;        w.mul_b = MB_TURN_K;
            end
            ST_UPD_HEAD: begin
                w.target = ST_EMIT;       w.op = OP_UPD_HEAD;
            end
            ST_EMIT: begin
                w.jcond = JC_OUT_FREE;    w.target = ST_WAIT;      w.op = OP_EMIT;
            end
            default: begin
                w.target = ST_WAIT;
            end
        endcase
        return w;
    endfunction

endpackage

### src/unicycle_pose_integrator_core.sv
// ----------------------------------------------------------------------------
// unicycle_pose_integrator_core
// One forward Euler step of the unicycle model per command.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel (i_cmd_valid / o_cmd_ready / i_cmd): speed, turn rate,
//   progress rate and step time. Pose channel (o_pose_valid / i_pose_ready /
//   o_pose): x, y, heading and progress after the step.
//   A command is taken only while the sequencer waits in its idle step. Each
//   command then goes through one load, CORDIC_STEPS micro-rotations of the
//   iterative CORDIC, six steps through the single shared multiplier, a
//   heading update and an emit step. The next command is taken only once the
//   sequencer is back in its idle step after the emit step.
//   The result sits in an output register; if it is still waiting when the
//   next result is ready, the sequencer holds in its emit step until the
//   receiver takes the old one.
//   Reset (synchronous, active low) clears x, y, heading and progress to zero
//   and empties the output register.
// ----------------------------------------------------------------------------
module unicycle_pose_integrator_core import upi_pkg::*; #(
    parameter int CORDIC_STEPS = 16,
    parameter int ANGLE_BITS   = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_cmd_valid,
    output logic  o_cmd_ready,
    input  t_cmd  i_cmd,
    output logic  o_pose_valid,
    input  logic  i_pose_ready,
    output t_pose o_pose
);

    t_dp_ctrl           dp_ctrl;
    t_cordic_ctrl       cordic_ctrl;
    t_seq_status        status;
    t_step              step;
    logic signed [31:0] cos_v;
    logic signed [31:0] sin_v;
    logic        [15:0] heading;
    logic               cordic_done;
    logic               out_free;

    assign status.in_valid    = i_cmd_valid;
    assign status.cordic_done = cordic_done;
    assign status.out_free    = out_free;

    upi_sequencer u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_status     (status),
        .o_dp_ctrl    (dp_ctrl),
        .o_cordic_ctrl(cordic_ctrl),
        .o_cmd_ready  (o_cmd_ready),
        .o_step       (step)
    );

    upi_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS),
        .ANGLE_BITS  (ANGLE_BITS)
    ) u_cordic (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (cordic_ctrl),
        .i_heading(heading),
        .o_cos    (cos_v),
        .o_sin    (sin_v),
        .o_done   (cordic_done)
    );

    upi_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (dp_ctrl),
        .i_cmd       (i_cmd),
        .i_cos       (cos_v),
        .i_sin       (sin_v),
        .i_pose_ready(i_pose_ready),
        .o_heading   (heading),
        .o_out_free  (out_free),
        .o_pose      (o_pose),
        .o_pose_valid(o_pose_valid)
    );

    // A taken command leaves the idle step at once
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd_valid && o_cmd_ready) |=> !o_cmd_ready)
        else $error("command ready stayed high after a transfer");

    // A result only appears out of the emit step
    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_pose_valid) |-> ($past(step) == ST_EMIT))
        else $error("pose valid rose outside the emit step");

    // A blocked output holds the sequencer in the emit step
    a_emit_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step == ST_EMIT && o_pose_valid && !i_pose_ready) |=> (step == ST_EMIT))
        else $error("sequencer left the emit step while the output was blocked");

endmodule

### src/upi_sequencer.sv
// ----------------------------------------------------------------------------
// upi_sequencer
// Step counter and microcode ROM; holds a step until its jump condition holds.
// ----------------------------------------------------------------------------
module upi_sequencer import upi_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_seq_status  i_status,
    output t_dp_ctrl     o_dp_ctrl,
    output t_cordic_ctrl o_cordic_ctrl,
    output logic         o_cmd_ready,
    output t_step        o_step
);

    t_step  r_step;
    t_step  n_step;
    t_uword uw;

    assign uw = ucode(r_step);

    // Step register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_WAIT;
        end else begin
            r_step <= n_step;
        end
    end

    // Next step: jump to target once the condition is met
    always_comb begin
        n_step = r_step;
        unique case (uw.jcond)
            JC_ALWAYS:      n_step = uw.target;
            JC_IN_VALID:    if (i_status.in_valid)    n_step = uw.target;
            JC_CORDIC_DONE: if (i_status.cordic_done) n_step = uw.target;
            JC_OUT_FREE:    if (i_status.out_free)    n_step = uw.target;
            default:        n_step = ST_WAIT;
        endcase
    end

    // Control outputs
    always_comb begin
        o_cmd_ready        = (r_step == ST_WAIT);
        o_dp_ctrl.take     = (uw.op == OP_LOAD) && i_status.in_valid;
        o_dp_ctrl.op       = uw.op;
        o_dp_ctrl.mul_a    = uw.mul_a;
        o_dp_ctrl.mul_b    = uw.mul_b;
        o_cordic_ctrl.load = (uw.op == OP_LOAD) && i_status.in_valid;
        o_cordic_ctrl.iter = (uw.op == OP_ITER);
        o_step             = r_step;
    end

endmodule

### src/upi_cordic.sv
// ----------------------------------------------------------------------------
// upi_cordic
// Iterative rotation-mode CORDIC: sine and cosine of the heading, one
// micro-rotation per cycle.
// ----------------------------------------------------------------------------
module upi_cordic import upi_pkg::*; #(
    parameter int CORDIC_STEPS = 16,
    parameter int ANGLE_BITS   = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cordic_ctrl       i_ctrl,
    input  logic        [15:0] i_heading,
    output logic signed [31:0] o_cos,
    output logic signed [31:0] o_sin,
    output logic               o_done
);

    localparam int AW = ANGLE_BITS + 1;
    localparam logic signed [AW-1:0] QUARTER  = AW'(longint'(1) << (ANGLE_BITS - 2));
    localparam logic signed [AW-1:0] HALF     = AW'(longint'(1) << (ANGLE_BITS - 1));
    localparam logic        [32:0]   RND_HALF = 33'(longint'(1) << (31 - ANGLE_BITS));
    localparam int                   ATAN_SH  = 32 - ANGLE_BITS;
    localparam logic [ATAN_IDX_W-1:0] IDX_LAST = ATAN_IDX_W'(CORDIC_STEPS - 1);

    logic signed [31:0]           r_x;
    logic signed [31:0]           r_y;
    logic signed [AW-1:0]         r_a;
    logic                         r_flip;
    logic        [ATAN_IDX_W-1:0] r_iter;

    logic signed [AW-1:0] a_scaled;
    logic signed [AW-1:0] a_fold;
    logic                 flip;
    logic        [32:0]   atan_sum;
    logic signed [AW-1:0] atan_step;
    logic signed [31:0]   dx;
    logic signed [31:0]   dy;

    // Heading to CORDIC angle resolution
    if (ANGLE_BITS >= 16) begin : g_up
        assign a_scaled = AW'(signed'({i_heading[15], i_heading})) <<< (ANGLE_BITS - 16);
    end else begin : g_dn
        logic signed [15:0] h_dn;
        assign h_dn     = signed'(i_heading) >>> (16 - ANGLE_BITS);
        assign a_scaled = AW'(h_dn);
    end

    // Fold into +/- a quarter turn
    always_comb begin
        a_fold = a_scaled;
        flip   = 1'b0;
        if (a_scaled > QUARTER) begin
            a_fold = a_scaled - HALF;
            flip   = 1'b1;
        end else if (a_scaled < -QUARTER) begin
            a_fold = a_scaled + HALF;
            flip   = 1'b1;
        end
    end

    // Arctangent of this step, rounded to the angle resolution
    assign atan_sum  = {1'b0, ATAN_TURN32[r_iter]} + RND_HALF;
    assign atan_step = AW'(atan_sum >> ATAN_SH);
    assign dx        = r_y >>> r_iter;
    assign dy        = r_x >>> r_iter;

    // Iteration counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iter <= '0;
        end else if (i_ctrl.load) begin
            r_iter <= '0;
        end else if (i_ctrl.iter) begin
            r_iter <= r_iter + 1'b1;
        end
    end

    // Vector and residual angle
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_x    <= INV_GAIN_Q30;
            r_y    <= '0;
            r_a    <= a_fold;
            r_flip <= flip;
        end else if (i_ctrl.iter) begin
            if (!r_a[AW-1]) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_a <= r_a - atan_step;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_a <= r_a + atan_step;
            end
        end
    end

    assign o_cos  = r_flip ? -r_x : r_x;
    assign o_sin  = r_flip ? -r_y : r_y;
    assign o_done = (r_iter == IDX_LAST);

endmodule

### src/upi_datapath.sv
// ----------------------------------------------------------------------------
// upi_datapath
// Command register, shared multiplier, pose state with saturating x, y and
// progress updates and a wrapping heading, and the output register.
// ----------------------------------------------------------------------------
module upi_datapath import upi_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_ctrl           i_ctrl,
    input  t_cmd               i_cmd,
    input  logic signed [31:0] i_cos,
    input  logic signed [31:0] i_sin,
    input  logic               i_pose_ready,
    output logic        [15:0] o_heading,
    output logic               o_out_free,
    output t_pose              o_pose,
    output logic               o_pose_valid
);

    localparam logic signed [65:0] RND_POS  = 66'sd1 <<< 41;
    localparam logic signed [65:0] RND_HEAD = 66'sd1 <<< 43;
    localparam logic signed [65:0] RND_PROG = 66'sd1 <<< 11;
    localparam logic signed [33:0] SAT_MAX  = 34'sd2147483647;
    localparam logic signed [33:0] SAT_MIN  = -34'sd2147483648;

    t_cmd               r_cmd;
    logic signed [65:0] r_prod;
    logic signed [32:0] r_vdt;
    logic signed [32:0] r_wdt;
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic        [15:0] r_heading;
    logic signed [31:0] r_prog;
    t_pose              r_pose;
    logic               r_pose_valid;

    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] rnd_pos;
    logic signed [65:0] rnd_head;
    logic signed [65:0] rnd_prog;
    logic signed [23:0] d_pos;
    logic signed [23:0] d_prog;

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [23:0] d);
        logic signed [33:0] s;
        s = 34'(a) + 34'(d);
        if (s > SAT_MAX) begin
            return 32'sh7FFFFFFF;
        end else if (s < SAT_MIN) begin
            return 32'sh80000000;
        end
        return s[31:0];
    endfunction

    // Operand selection
    always_comb begin
        unique case (i_ctrl.mul_a)
            MA_SPEED: mul_a = 33'(r_cmd.speed);
            MA_TURN:  mul_a = 33'(r_cmd.turn_rate);
            MA_PROG:  mul_a = 33'(r_cmd.progress_rate);
            MA_VDT:   mul_a = r_vdt;
            MA_WDT:   mul_a = r_wdt;
            default:  mul_a = '0;
        endcase
        unique case (i_ctrl.mul_b)
            MB_DT:     mul_b = signed'({17'd0, r_cmd.step_time});
            MB_COS:    mul_b = 33'(i_cos);
            MB_SIN:    mul_b = 33'(i_sin);
            MB_TURN_K: mul_b = TURN_RECIP_Q32;
            default:   mul_b = '0;
        endcase
    end

    // Round half up, then floor shift
    assign rnd_pos  = r_prod + RND_POS;
    assign rnd_head = r_prod + RND_HEAD;
    assign rnd_prog = r_prod + RND_PROG;
    assign d_pos    = rnd_pos[65:42];
    assign d_prog   = rnd_prog[35:12];

    // Command latch, product register, intermediate products
    always_ff @(posedge i_clk) begin
        if (i_ctrl.take) begin
            r_cmd <= i_cmd;
        end
        r_prod <= mul_a * mul_b;
        if (i_ctrl.op == OP_SET_VDT) begin
            r_vdt <= r_prod[32:0];
        end
        if (i_ctrl.op == OP_SET_WDT) begin
            r_wdt <= r_prod[32:0];
        end
    end

    // Pose state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x       <= '0;
            r_y       <= '0;
            r_heading <= '0;
            r_prog    <= '0;
        end else begin
            unique case (i_ctrl.op)
                OP_UPD_PROG: r_prog    <= sat_add(r_prog, d_prog);
                OP_UPD_X:    r_x       <= sat_add(r_x, d_pos);
                OP_UPD_Y:    r_y       <= sat_add(r_y, d_pos);
                OP_UPD_HEAD: r_heading <= r_heading + rnd_head[59:44];
                default:     ;
            endcase
        end
    end

    // Output register: loads when empty or being drained
    assign o_out_free = !r_pose_valid || i_pose_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pose_valid <= 1'b0;
        end else if ((i_ctrl.op == OP_EMIT) && o_out_free) begin
            r_pose_valid <= 1'b1;
        end else if (i_pose_ready) begin
            r_pose_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((i_ctrl.op == OP_EMIT) && o_out_free) begin
            r_pose.out_x        <= r_x;
            r_pose.out_y        <= r_y;
            r_pose.out_heading  <= r_heading;
            r_pose.out_progress <= r_prog;
        end
    end

    assign o_heading    = r_heading;
    assign o_pose       = r_pose;
    assign o_pose_valid = r_pose_valid;

endmodule

### verif/tb_unicycle_pose_integrator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_unicycle_pose_integrator_core
// Self-checking bench for the pose integrator: commands are driven on the
// command channel and every pose on the pose channel is compared against a
// fixed-point Euler/CORDIC predictor kept in step with the accepted commands.
// Directed corners first, then random commands with steering to the CORDIC
// fold boundaries.
// ----------------------------------------------------------------------------
module tb_unicycle_pose_integrator_core;
    import upi_pkg::*;

    localparam int CORDIC_STEPS = 16;
    localparam int ANGLE_BITS   = 16;
    localparam int AB_UP = (ANGLE_BITS >= 16) ? (ANGLE_BITS - 16) : 0;
    localparam int AB_DN = (ANGLE_BITS < 16) ? (16 - ANGLE_BITS) : 0;

    localparam longint GAIN_INV_Q30  = 64'sd652032874;
    localparam longint RAD_TO_TURN32 = 64'sd683565276;
    localparam int     I32_MAX       = 32'sh7fff_ffff;
    localparam int     I32_MIN       = 32'sh8000_0000;
    localparam int     RAND_ITEMS    = 1100;
    localparam int     DRAIN_CYCLES  = 40;

    // atan(2^-i) in units of 2^-32 turn
    localparam longint ARCTAN_TURN32 [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    // Pose predictor plus queue of poses still owed by the block
    class pose_ledger;
        int          pos_x;
        int          pos_y;
        bit   [15:0] heading;
        int          progress;
        t_pose       due_poses[$];
        int          errors;

        function new();
            pos_x    = 0;
            pos_y    = 0;
            heading  = '0;
            progress = 0;
            errors   = 0;
        endfunction

        function int pending();
            return due_poses.size();
        endfunction

        // floor((v + half lsb) / 2^s)
        function longint rounded_shr(longint v, int s);
            return (v + (longint'(1) << (s - 1))) >>> s;
        endfunction

        function int clamp_sum(int a, longint d);
            longint s;
            s = longint'(a) + d;
            if (s > longint'(I32_MAX)) return I32_MAX;
            if (s < longint'(I32_MIN)) return I32_MIN;
            return int'(s);
        endfunction

        // One Euler step for an accepted command; queue the resulting pose
        function void advance_pose(t_cmd c);
            longint v, w, vs, dt, vdt, dpsi;
            longint ang, quarter, half, cx, sy, dx, dy, step;
            bit     flip;
            int     i;
            t_pose  p;
            v  = c.speed;
            w  = c.turn_rate;
            vs = c.progress_rate;
            dt = longint'(c.step_time);

            // CORDIC rotation on the old heading, folded into +/- a quarter turn
            ang     = longint'($signed(heading));
            quarter = longint'(1) << (ANGLE_BITS - 2);
            half    = longint'(1) << (ANGLE_BITS - 1);
            flip    = 1'b0;
            if (ANGLE_BITS >= 16) ang = ang <<< AB_UP;
            else                  ang = ang >>> AB_DN;
            if (ang > quarter) begin
                ang  = ang - half;
                flip = 1'b1;
            end else if (ang < -quarter) begin
                ang  = ang + half;
                flip = 1'b1;
            end
            cx = GAIN_INV_Q30;
            sy = 0;
            for (i = 0; i < CORDIC_STEPS && i < 24; i++) begin
                step = (ARCTAN_TURN32[i] + (longint'(1) << (31 - ANGLE_BITS)))
                       >>> (32 - ANGLE_BITS);
                dx = sy >>> i;
                dy = cx >>> i;
                if (ang >= 0) begin
                    cx  = cx - dx;
                    sy  = sy + dy;
                    ang = ang - step;
                end else begin
                    cx  = cx + dx;
                    sy  = sy - dy;
                    ang = ang + step;
                end
            end
            if (flip) begin
                cx = -cx;
                sy = -sy;
            end

            // State update
            vdt      = v * dt;
            pos_x    = clamp_sum(pos_x, rounded_shr(vdt * cx, 42));
            pos_y    = clamp_sum(pos_y, rounded_shr(vdt * sy, 42));
            dpsi     = rounded_shr((w * dt) * RAD_TO_TURN32, 44);
            heading  = heading + dpsi[15:0];
            progress = clamp_sum(progress, rounded_shr(vs * dt, 12));

            p.out_x        = pos_x;
            p.out_y        = pos_y;
            p.out_heading  = heading;
            p.out_progress = progress;
            due_poses.push_back(p);
        endfunction

        function void cmp_field(string tag, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t ns: %s mismatch, expected %h, actual %h",
                         $time, tag, want, got);
            end
        endfunction

        function void check_pose(t_pose got);
            t_pose want;
            if (due_poses.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected pose transfer, expected none, actual %h",
                         $time, got);
                return;
            end
            want = due_poses.pop_front();
            cmp_field("out_x", want.out_x, got.out_x);
            cmp_field("out_y", want.out_y, got.out_y);
            cmp_field("out_heading", {16'd0, want.out_heading}, {16'd0, got.out_heading});
            cmp_field("out_progress", want.out_progress, got.out_progress);
        endfunction
    endclass

    logic  i_clk        = 1'b0;
    logic  i_rst_n      = 1'b0;
    logic  i_cmd_valid  = 1'b0;
    t_cmd  i_cmd        = '0;
    logic  i_pose_ready = 1'b0;
    logic  o_cmd_ready;
    logic  o_pose_valid;
    t_pose o_pose;

    bit         quiet      = 1'b0;  // no idling on either side while set
    int         stall_left = 0;
    pose_ledger book       = new();

    unicycle_pose_integrator_core #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .ANGLE_BITS   (ANGLE_BITS)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (i_cmd_valid),
        .o_cmd_ready  (o_cmd_ready),
        .i_cmd        (i_cmd),
        .o_pose_valid (o_pose_valid),
        .i_pose_ready (i_pose_ready),
        .o_pose       (o_pose)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Pose receiver: random back-pressure with occasional long stalls
    always @(negedge i_clk) begin
        if (quiet) begin
            i_pose_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            i_pose_ready <= 1'b0;
        end else if ($urandom_range(0, 299) == 0) begin
            stall_left   <= $urandom_range(20, 60);
            i_pose_ready <= 1'b0;
        end else begin
            i_pose_ready <= ($urandom_range(0, 99) >= 28);
        end
    end

    // Pose monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_pose_valid && i_pose_ready)
            book.check_pose(o_pose);
    end

    function automatic t_cmd cmd_of(int sp, int tr, int pr, int dt);
        t_cmd c;
        c.speed         = sp[15:0];
        c.turn_rate     = tr[15:0];
        c.progress_rate = pr[15:0];
        c.step_time     = dt[15:0];
        return c;
    endfunction

    // Rate field: mostly full range, some extremes and small values
    function automatic logic [15:0] rand_rate();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0:       return 16'h8000;
                    1:       return 16'h7fff;
                    2:       return 16'h0000;
                    3:       return 16'hffff;
                    default: return 16'h0001;
                endcase
            end
            1:       return 16'($urandom_range(0, 128)) - 16'd64;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_cmd rand_cmd();
        t_cmd c;
        c.speed         = rand_rate();
        c.turn_rate     = rand_rate();
        c.progress_rate = rand_rate();
        case ($urandom_range(0, 9))
            0:       c.step_time = 16'd0;
            1:       c.step_time = 16'hffff;
            2:       c.step_time = 16'($urandom_range(1, 255));
            default: c.step_time = 16'($urandom);
        endcase
        return c;
    endfunction

    // Drive one command; called and returns at a falling edge
    task automatic send_cmd(input t_cmd c);
        int gap;
        gap = 0;
        if (!quiet) begin
            if ($urandom_range(0, 19) == 0) gap = $urandom_range(1, 40);
            else while ($urandom_range(0, 99) < 28) gap++;
        end
        if (gap > 0) begin
            i_cmd_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_cmd_valid <= 1'b1;
        i_cmd       <= c;
        @(posedge i_clk);
        while (!o_cmd_ready) @(posedge i_clk);
        book.advance_pose(c);
        @(negedge i_clk);
    endtask

    // Turn in place until the predicted heading equals goal
    task automatic steer_heading(input bit [15:0] goal);
        longint d, w;
        bit [15:0] diff;
        diff = goal - book.heading;
        d    = longint'($signed(diff));
        if (d > 2 || d < -2) begin
            w = (d * (longint'(1) << 44)) / (longint'(65535) * RAD_TO_TURN32);
            send_cmd(cmd_of(0, int'(w), int'(rand_rate()), 65535));
        end
        while (book.heading != goal) begin
            diff = goal - book.heading;
            send_cmd(cmd_of(0, diff[15] ? -1 : 1, 0, 25736));
        end
    endtask

    // Stimulus
    initial begin
        bit [15:0] goal;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed corners: extremes, zero step, wrap, rounding ties
        send_cmd(cmd_of(0, 0, 0, 0));
        send_cmd(cmd_of(32767, 0, 32767, 65535));
        send_cmd(cmd_of(-32768, 0, -32768, 65535));
        send_cmd(cmd_of(32767, 32767, 32767, 0));
        send_cmd(cmd_of(-32768, -32768, -32768, 0));
        send_cmd(cmd_of(0, 32767, 0, 65535));
        send_cmd(cmd_of(0, -32768, 0, 65535));
        send_cmd(cmd_of(1, 1, 1, 1));
        send_cmd(cmd_of(-1, -1, -1, 1));
        send_cmd(cmd_of(1, 0, 1, 2048));
        send_cmd(cmd_of(-1, 0, -1, 2048));
        send_cmd(cmd_of(-1, 0, -1, 65535));
        send_cmd(cmd_of(32'h5555, 32'haaaa, 32'h5555, 32'haaaa));
        send_cmd(cmd_of(32'haaaa, 32'h5555, 32'haaaa, 32'h5555));
        send_cmd(cmd_of(32767, 32767, -32768, 65535));

        // Random commands, sometimes from a fold-boundary heading
        for (int n = 0; n < RAND_ITEMS; n++) begin
            quiet = (n >= 300 && n < 450);
            if (n == 700) begin
                i_cmd_valid <= 1'b0;
                @(negedge i_clk);
                while (book.pending() != 0) @(negedge i_clk);
            end
            if ($urandom_range(0, 9) == 0) begin
                case ($urandom_range(0, 9))
                    0:       goal = 16'd0;
                    1:       goal = 16'd8192;
                    2:       goal = 16'd16384;
                    3:       goal = 16'd16385;
                    4:       goal = 16'd32767;
                    5:       goal = 16'd32768;
                    6:       goal = 16'd49151;
                    7:       goal = 16'd49152;
                    8:       goal = 16'd57344;
                    default: goal = 16'($urandom);
                endcase
                steer_heading(goal);
            end
            send_cmd(rand_cmd());
        end

        // Drain
        i_cmd_valid <= 1'b0;
        @(negedge i_clk);
        while (book.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (book.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog
    initial begin
        #(64'd100_000_000);
        $display("Regression FAIL");
        $finish;
    end

endmodule

### unicycle_pose_integrator_core.f
src/upi_pkg.sv
src/upi_sequencer.sv
src/upi_cordic.sv
src/upi_datapath.sv
src/unicycle_pose_integrator_core.sv
verif/tb_unicycle_pose_integrator_core.sv
